### rtl/sm64bg_pkg.sv
package sm64bg_pkg;

	localparam int unsigned WORD_W = 64;
	localparam int unsigned HALF_W = 32;

	localparam logic [WORD_W-1:0] GOLDEN_STEP = 64'h9E37_79B9_7F4A_7C15;
	localparam logic [WORD_W-1:0] MIX_MUL_A   = 64'hBF58_476D_1CE4_E5B9;
	localparam logic [WORD_W-1:0] MIX_MUL_B   = 64'h94D0_49BB_1331_11EB;

	localparam int unsigned SHIFT_A = 30;
	localparam int unsigned SHIFT_B = 27;
	localparam int unsigned SHIFT_C = 31;

	typedef logic [WORD_W-1:0] word_t;

	localparam logic OP_RAW     = 1'b0;
	localparam logic OP_BOUNDED = 1'b1;

	typedef enum logic [1:0] {
		MS_LO_LO = 2'd0,
		MS_LO_HI = 2'd1,
		MS_HI_LO = 2'd2,
		MS_SUM   = 2'd3
	} mul_step_t;

endpackage

### rtl/splitmix64_bounded_generator.sv
// SplitMix64 generator with optional reduction below a bound. One request is in
// flight at a time. A raw request goes through the counter add on accept, then
// two 64-bit multiplies that each run the LO_LO, LO_HI, HI_LO and SUM steps on
// one shared 32x32 multiplier, then the result hand-off. A bounded request adds
// a radix-2 restoring divider pass over all 64 quotient bits (one 65-bit compare
// and subtract per cycle). A bound of zero answers 0 and leaves the counter
// alone. Writing the seed reloads the counter; write it only while the block is
// idle. The output register lets a new request start while the previous result
// still waits to be taken.
module splitmix64_bounded_generator (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               seed_we,
	input  sm64bg_pkg::word_t  seed,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               op,
	input  sm64bg_pkg::word_t  upper,
	output logic               out_valid,
	input  logic               out_ready,
	output sm64bg_pkg::word_t  value
);
	import sm64bg_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_WAIT
	} state_t;

	localparam int unsigned CNT_W = $clog2(WORD_W);

	state_t                  state_q;
	mul_step_t               step_q;
	logic                    mul_sel_q;
	logic                    op_q;
	word_t                   upper_q;
	word_t                   gen_state_q;
	word_t                   z_q;
	word_t                   prod_q;
	word_t                   acc_q;
	word_t                   rem_q;
	word_t                   quo_q;
	word_t                   res_q;
	logic [CNT_W-1:0]        cnt_q;
	logic                    out_valid_q;
	word_t                   value_q;

	word_t                   next_gen;
	word_t                   mul_const;
	logic [HALF_W-1:0]       mul_a;
	logic [HALF_W-1:0]       mul_b;
	word_t                   mul_full;
	word_t                   z_sum;
	logic [WORD_W:0]         rem_shift;
	logic [WORD_W:0]         rem_diff;
	word_t                   rem_next;
	logic                    in_fire;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign value     = value_q;

	assign next_gen  = gen_state_q + GOLDEN_STEP;
	assign mul_const = mul_sel_q ? MIX_MUL_B : MIX_MUL_A;

	always_comb begin
		case (step_q)
			MS_LO_LO: begin
				mul_a = z_q[HALF_W-1:0];
				mul_b = mul_const[HALF_W-1:0];
			end
			MS_LO_HI: begin
				mul_a = z_q[HALF_W-1:0];
				mul_b = mul_const[WORD_W-1:HALF_W];
			end
			MS_HI_LO: begin
				mul_a = z_q[WORD_W-1:HALF_W];
				mul_b = mul_const[HALF_W-1:0];
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_full  = WORD_W'(mul_a) * WORD_W'(mul_b);
	assign z_sum     = acc_q + {prod_q[HALF_W-1:0], {HALF_W{1'b0}}};

	assign rem_shift = {rem_q, quo_q[WORD_W-1]};
	assign rem_diff  = rem_shift - {1'b0, upper_q};
	assign rem_next  = rem_diff[WORD_W] ? rem_shift[WORD_W-1:0] : rem_diff[WORD_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= MS_LO_LO;
			mul_sel_q   <= 1'b0;
			cnt_q       <= '0;
			gen_state_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (seed_we) begin
				gen_state_q <= seed;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						op_q    <= op;
						upper_q <= upper;
						if (op == OP_BOUNDED && upper == '0) begin
							res_q   <= '0;
							state_q <= ST_WAIT;
						end else begin
							gen_state_q <= next_gen;
							z_q         <= next_gen ^ (next_gen >> SHIFT_A);
							mul_sel_q   <= 1'b0;
							step_q      <= MS_LO_LO;
							state_q     <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					prod_q <= mul_full;
					case (step_q)
						MS_LO_LO: begin
							step_q <= MS_LO_HI;
						end
						MS_LO_HI: begin
							acc_q  <= prod_q;
							step_q <= MS_HI_LO;
						end
						MS_HI_LO: begin
							acc_q  <= z_sum;
							step_q <= MS_SUM;
						end
						default: begin
							step_q <= MS_LO_LO;
							if (!mul_sel_q) begin
								z_q       <= z_sum ^ (z_sum >> SHIFT_B);
								mul_sel_q <= 1'b1;
							end else if (op_q == OP_BOUNDED) begin
								quo_q   <= z_sum ^ (z_sum >> SHIFT_C);
								rem_q   <= '0;
								cnt_q   <= '0;
								state_q <= ST_DIV;
							end else begin
								res_q   <= z_sum ^ (z_sum >> SHIFT_C);
								state_q <= ST_WAIT;
							end
						end
					endcase
				end
				ST_DIV: begin
					rem_q <= rem_next;
					quo_q <= {quo_q[WORD_W-2:0], 1'b0};
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(WORD_W - 1)) begin
						res_q   <= rem_next;
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					if (!out_valid_q || out_ready) begin
						value_q     <= res_q;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !in_ready)
		else $error("request accepted but block still ready");

	a_rem_below_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (rem_q < upper_q))
		else $error("partial remainder not below bound");

	a_div_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && cnt_q == CNT_W'(WORD_W - 1)) |=> (state_q == ST_WAIT))
		else $error("divider did not finish after last step");

	a_seed_load: assert property (@(posedge clk) disable iff (!arst_n)
		(seed_we && state_q == ST_IDLE && !in_valid) |=> (gen_state_q == $past(seed)))
		else $error("seed write not loaded into counter");

endmodule
